>>> design/nps_pkg.sv
// Shared types, constants and the microcode program of the node placement selector.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps

package nps_pkg;

    // Table geometry and field widths
    localparam int NODES    = 16;
    localparam int IDX_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int SLOT_W   = 4;
    localparam int UPC_W    = 4;
    localparam int SPREAD_W = 32;
    localparam int BIT_W    = $clog2(SPREAD_W);
    localparam int TASK_W   = 16;
    localparam int VRAM_W   = 20;
    localparam int LOAD_W   = 16;

    // Input word: one command
    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic              present;
        logic              is_self;
        logic [7:0]        gpus;
        logic [VRAM_W-1:0] vram_mib;
        logic [9:0]        cores;
        logic [23:0]       mem_mib;
        logic [LOAD_W-1:0] load_q8;
        logic [1:0]        strategy;
        logic              has_target;
    } nps_in_t;

    // Output word: one result
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] chosen;
        logic [1:0]        error_code;
    } nps_out_t;

    // Stored node resources (62 bits) and flags with load (18 bits)
    typedef struct packed {
        logic [23:0]       mem_mib;
        logic [9:0]        cores;
        logic [VRAM_W-1:0] vram_mib;
        logic [7:0]        gpus;
    } res_t;

    typedef struct packed {
        logic [LOAD_W-1:0] load_q8;
        logic              is_self;
        logic              present;
    } flags_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_TGT_ABSENT,
        ERR_TGT_SHORT,
        ERR_NONE_ELIG
    } err_t;

    localparam logic [1:0] STRAT_VRAM   = 2'd0;
    localparam logic [1:0] STRAT_LOAD   = 2'd1;
    localparam logic [1:0] STRAT_SPREAD = 2'd2;
    localparam logic [1:0] STRAT_PACK   = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;

    // Datapath operations driven by the control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TARGET,
        OP_SCAN,
        OP_RESTART,
        OP_SELF,
        OP_MODINIT,
        OP_MODSTEP,
        OP_PICK,
        OP_COMMIT,
        OP_WRITE
    } op_t;

    // Jump conditions, evaluated on the state before the step executes
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_IS_WRITE,
        C_NO_TARGET,
        C_IDX_MORE,
        C_COUNT_NZ,
        C_SELF_MORE,
        C_COUNT_ZERO,
        C_NOT_SPREAD,
        C_MOD_MORE
    } cond_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  jump;
    } uword_t;

    // Microcode addresses
    localparam upc_t UA_CLEAR   = 4'd0;
    localparam upc_t UA_TGTSEL  = 4'd1;
    localparam upc_t UA_TARGET  = 4'd2;
    localparam upc_t UA_SCAN    = 4'd3;
    localparam upc_t UA_REST1   = 4'd4;
    localparam upc_t UA_SELF    = 4'd5;
    localparam upc_t UA_REST2   = 4'd6;
    localparam upc_t UA_MODINIT = 4'd7;
    localparam upc_t UA_MODSTEP = 4'd8;
    localparam upc_t UA_PICK    = 4'd9;
    localparam upc_t UA_COMMIT  = 4'd10;
    localparam upc_t UA_WRITE   = 4'd11;

    // The placement program. Each step runs its operation, then jumps when
    // its condition holds and otherwise falls through to the next step.
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        begin
            case (addr)
                UA_CLEAR:   w = '{OP_CLEAR,   C_IS_WRITE,   UA_WRITE};
                UA_TGTSEL:  w = '{OP_NOP,     C_NO_TARGET,  UA_SCAN};
                UA_TARGET:  w = '{OP_TARGET,  C_ALWAYS,     UA_COMMIT};
                UA_SCAN:    w = '{OP_SCAN,    C_IDX_MORE,   UA_SCAN};
                UA_REST1:   w = '{OP_RESTART, C_COUNT_NZ,   UA_REST2};
                UA_SELF:    w = '{OP_SELF,    C_SELF_MORE,  UA_SELF};
                UA_REST2:   w = '{OP_RESTART, C_COUNT_ZERO, UA_COMMIT};
                UA_MODINIT: w = '{OP_MODINIT, C_NOT_SPREAD, UA_PICK};
                UA_MODSTEP: w = '{OP_MODSTEP, C_MOD_MORE,   UA_MODSTEP};
                UA_PICK:    w = '{OP_PICK,    C_IDX_MORE,   UA_PICK};
                UA_COMMIT:  w = '{OP_COMMIT,  C_ALWAYS,     UA_CLEAR};
                UA_WRITE:   w = '{OP_WRITE,   C_ALWAYS,     UA_CLEAR};
                default:    w = '{OP_COMMIT,  C_ALWAYS,     UA_CLEAR};
            endcase
            return w;
        end
    endfunction

    // A node qualifies when it meets every nonzero minimum of the command.
    function automatic logic qualifies(input res_t r, input nps_in_t c);
        logic q;
        begin
            q = 1'b1;
            if ((c.gpus != '0) && (r.gpus < c.gpus)) q = 1'b0;
            if ((c.vram_mib != '0) && (r.vram_mib < c.vram_mib)) q = 1'b0;
            if ((c.cores != '0) && (r.cores < c.cores)) q = 1'b0;
            if ((c.mem_mib != '0) && (r.mem_mib < c.mem_mib)) q = 1'b0;
            return q;
        end
    endfunction

endpackage

>>> design/node_placement_selector.sv
// Node placement selector: node table, microcode sequencer and its datapath.
// Depends on nps_pkg for word types, constants and the microcode program.
`timescale 1ns / 1ps

// A table write runs the clear step and then the write step; a placement runs scans for
// remote and self nodes, a pick pass and, under the spread strategy, the one-bit-per-step
// spread remainder. Busy is high from acceptance until the result cycle, in which the next
// word can already be taken.
// Results appear for one cycle with done; the receiver cannot stall them.
// Reset clears all presence flags, task counts and the spread counter at once.
module node_placement_selector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nps_pkg::nps_in_t  cmd,
    output logic              done,
    output nps_pkg::nps_out_t result
);
    import nps_pkg::*;

    // Sequencer and datapath registers
    logic                busy_reg, busy_next;
    upc_t                upc_reg, upc_next;
    nps_in_t             cmd_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rank_reg, rank_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [BIT_W-1:0]    bitcnt_reg, bitcnt_next;
    logic [NODES-1:0]    elig_reg, elig_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    err_t                err_reg, err_next;
    logic [VRAM_W-1:0]   best_vram_reg, best_vram_next;
    logic [LOAD_W-1:0]   best_load_reg, best_load_next;
    logic [TASK_W-1:0]   best_task_reg, best_task_next;
    logic [SPREAD_W-1:0] spread_reg, spread_next;
    logic                done_reg, done_next;
    nps_out_t            result_reg, result_next;

    // Node table
    res_t                res_reg   [NODES];
    flags_t              flags_reg [NODES];
    logic [TASK_W-1:0]   task_reg  [NODES];

    // Table write controls
    logic                tbl_wr_en;
    logic                task_wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [TASK_W-1:0]   task_wr_data;

    // Decode and read-side signals
    uword_t              uw;
    logic                take_jump;
    logic [IDX_W-1:0]    rd_addr;
    res_t                rd_res;
    flags_t              rd_flags;
    logic [TASK_W-1:0]   rd_task;
    logic                qual;
    logic                self_hit;
    logic                scan_hit;
    logic                slot_ok;
    logic                idx_last;
    logic                better;
    logic [CNT_W:0]      mod_shift;

    assign uw       = ucode_rom(upc_reg);
    assign slot_ok  = (int'(cmd_reg.slot) < NODES);
    assign idx_last = (idx_reg == IDX_W'(NODES - 1));

    // Single read port; the operation chooses the address.
    always_comb
    begin
        case (uw.op)
            OP_TARGET: rd_addr = IDX_W'(cmd_reg.slot);
            OP_COMMIT: rd_addr = pick_reg;
            default:   rd_addr = idx_reg;
        endcase
    end

    assign rd_res   = res_reg[rd_addr];
    assign rd_flags = flags_reg[rd_addr];
    assign rd_task  = task_reg[rd_addr];
    assign qual     = qualifies(rd_res, cmd_reg);
    assign self_hit = rd_flags.present && rd_flags.is_self && qual;
    assign scan_hit = rd_flags.present && !rd_flags.is_self && qual;

    // Selection compare for the current eligible entry
    always_comb
    begin
        better = 1'b0;
        if (!found_reg) begin
            better = (cmd_reg.strategy != STRAT_SPREAD) || (rank_reg == rem_reg);
        end else begin
            case (cmd_reg.strategy)
                STRAT_VRAM: better = (rd_res.vram_mib > best_vram_reg);
                STRAT_LOAD: better = (rd_flags.load_q8 < best_load_reg);
                STRAT_PACK: better = (rd_task > best_task_reg);
                default:    better = 1'b0;
            endcase
        end
        better = better && elig_reg[idx_reg];
    end

    // One restoring step of spread counter modulo eligible count
    assign mod_shift = {rem_reg, spread_reg[bitcnt_reg]};

    // Jump condition of the current step
    always_comb
    begin
        case (uw.cond)
            C_NEXT:       take_jump = 1'b0;
            C_ALWAYS:     take_jump = 1'b1;
            C_IS_WRITE:   take_jump = (cmd_reg.func == FUNC_WRITE);
            C_NO_TARGET:  take_jump = !cmd_reg.has_target;
            C_IDX_MORE:   take_jump = !idx_last;
            C_COUNT_NZ:   take_jump = (count_reg != '0);
            C_SELF_MORE:  take_jump = !self_hit && !idx_last;
            C_COUNT_ZERO: take_jump = (count_reg == '0);
            C_NOT_SPREAD: take_jump = (cmd_reg.strategy != STRAT_SPREAD);
            C_MOD_MORE:   take_jump = (bitcnt_reg != '0);
            default:      take_jump = 1'b0;
        endcase
    end

    // Sequencer: step counter and busy
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                upc_next  = UA_CLEAR;
            end
        end else begin
            upc_next = take_jump ? uw.jump : upc_reg + 1'b1;
            if ((uw.op == OP_COMMIT) || (uw.op == OP_WRITE)) begin
                busy_next = 1'b0;
            end
        end
    end

    // Datapath: what each operation does
    always_comb
    begin
        idx_next       = idx_reg;
        count_next     = count_reg;
        rank_next      = rank_reg;
        rem_next       = rem_reg;
        bitcnt_next    = bitcnt_reg;
        elig_next      = elig_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        err_next       = err_reg;
        best_vram_next = best_vram_reg;
        best_load_next = best_load_reg;
        best_task_next = best_task_reg;
        spread_next    = spread_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        tbl_wr_en      = 1'b0;
        task_wr_en     = 1'b0;
        wr_addr        = pick_reg;
        task_wr_data   = rd_task;

        if (busy_reg) begin
            case (uw.op)
                OP_CLEAR:
                begin
                    idx_next   = '0;
                    count_next = '0;
                    rank_next  = '0;
                    rem_next   = '0;
                    elig_next  = '0;
                    found_next = 1'b0;
                    err_next   = ERR_NONE_ELIG;
                end
                OP_TARGET:
                begin
                    if (!slot_ok || !rd_flags.present) begin
                        err_next = ERR_TGT_ABSENT;
                    end else if (!qual) begin
                        err_next = ERR_TGT_SHORT;
                    end else begin
                        found_next = 1'b1;
                        pick_next  = IDX_W'(cmd_reg.slot);
                    end
                end
                OP_SCAN:
                begin
                    elig_next[idx_reg] = scan_hit;
                    if (scan_hit) begin
                        count_next = count_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                OP_RESTART:
                begin
                    idx_next = '0;
                end
                OP_SELF:
                begin
                    if (self_hit) begin
                        elig_next[idx_reg] = 1'b1;
                        count_next         = CNT_W'(1);
                    end
                    idx_next = idx_reg + 1'b1;
                end
                OP_MODINIT:
                begin
                    rem_next    = '0;
                    bitcnt_next = BIT_W'(SPREAD_W - 1);
                end
                OP_MODSTEP:
                begin
                    if (mod_shift >= {1'b0, count_reg}) begin
                        rem_next = CNT_W'(mod_shift - {1'b0, count_reg});
                    end else begin
                        rem_next = CNT_W'(mod_shift);
                    end
                    bitcnt_next = bitcnt_reg - 1'b1;
                end
                OP_PICK:
                begin
                    if (better) begin
                        found_next     = 1'b1;
                        pick_next      = idx_reg;
                        best_vram_next = rd_res.vram_mib;
                        best_load_next = rd_flags.load_q8;
                        best_task_next = rd_task;
                    end
                    if (elig_reg[idx_reg]) begin
                        rank_next = rank_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                OP_COMMIT:
                begin
                    done_next = 1'b1;
                    if (found_reg) begin
                        result_next.ok         = 1'b1;
                        result_next.chosen     = SLOT_W'(pick_reg);
                        result_next.error_code = ERR_NONE;
                        task_wr_en             = 1'b1;
                        wr_addr                = pick_reg;
                        if (rd_task != '1) begin
                            task_wr_data = rd_task + 1'b1;
                        end
                        if (cmd_reg.strategy == STRAT_SPREAD) begin
                            spread_next = spread_reg + 1'b1;
                        end
                    end else begin
                        result_next.ok         = 1'b0;
                        result_next.chosen     = '0;
                        result_next.error_code = err_reg;
                    end
                end
                OP_WRITE:
                begin
                    done_next = 1'b1;
                    wr_addr   = IDX_W'(cmd_reg.slot);
                    if (slot_ok) begin
                        tbl_wr_en              = 1'b1;
                        task_wr_en             = !cmd_reg.present;
                        task_wr_data           = '0;
                        result_next.ok         = 1'b1;
                        result_next.chosen     = cmd_reg.slot;
                        result_next.error_code = ERR_NONE;
                    end else begin
                        result_next.ok         = 1'b0;
                        result_next.chosen     = '0;
                        result_next.error_code = ERR_TGT_ABSENT;
                    end
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            upc_reg    <= UA_CLEAR;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            spread_reg <= '0;
        end else begin
            busy_reg   <= busy_next;
            upc_reg    <= upc_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            spread_reg <= spread_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start) begin
            cmd_reg <= cmd;
        end
        idx_reg       <= idx_next;
        count_reg     <= count_next;
        rank_reg      <= rank_next;
        rem_reg       <= rem_next;
        bitcnt_reg    <= bitcnt_next;
        elig_reg      <= elig_next;
        pick_reg      <= pick_next;
        err_reg       <= err_next;
        best_vram_reg <= best_vram_next;
        best_load_reg <= best_load_next;
        best_task_reg <= best_task_next;
        result_reg    <= result_next;
    end

    // Node resources hold no reset; only present entries are ever read.
    always_ff @(posedge clk)
    begin
        if (tbl_wr_en) begin
            res_reg[wr_addr] <= '{cmd_reg.mem_mib, cmd_reg.cores,
                                  cmd_reg.vram_mib, cmd_reg.gpus};
        end
    end

    // Flags and task counts clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int n = 0; n < NODES; n++) begin
                flags_reg[n] <= '0;
                task_reg[n]  <= '0;
            end
        end else begin
            if (tbl_wr_en) begin
                flags_reg[wr_addr] <= '{cmd_reg.load_q8, cmd_reg.is_self,
                                        cmd_reg.present};
            end
            if (task_wr_en) begin
                task_reg[wr_addr] <= task_wr_data;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
